// ===== design/mrc_pkg.sv =====
// Package: shared types, constants and CRC function for the Modbus RTU response checker.
`default_nettype none
package mrc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W = 9;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [POS_W-1:0] MIN_FRAME = 9'd5;
  localparam logic [POS_W-1:0] FAULT_MIN_LEN = 9'd7;
  localparam logic [POS_W-1:0] POS_ADDR = 9'd0;
  localparam logic [POS_W-1:0] POS_FUNC = 9'd1;
  localparam logic [POS_W-1:0] POS_COUNT = 9'd2;
  localparam logic [POS_W-1:0] POS_DATA = 9'd3;

  localparam logic [CFG_IDX_W-1:0] REG_EXP_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_FUNC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_IDX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COIL_IDX = 3'd4;

  localparam logic [BYTE_W-1:0] FUNC_RESET = 8'h03;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_LENGTH = 3'd1;
  localparam logic [2:0] ST_ADDRESS = 3'd2;
  localparam logic [2:0] ST_FUNCTION = 3'd3;
  localparam logic [2:0] ST_COUNT = 3'd4;
  localparam logic [2:0] ST_CRC = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic last_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [POS_W-1:0] frame_length;
    logic [WORD_W-1:0] value_word;
    logic value_bit;
    logic [WORD_W-1:0] fault_word;
  } out_rsp_t;

  typedef struct packed {
    logic [BYTE_W-1:0] expected_address;
    logic [BYTE_W-1:0] expected_function;
    logic [BYTE_W-1:0] expected_byte_count;
    logic [6:0] value_word_index;
    logic [10:0] coil_index;
  } cfg_t;

  // CRC-16/MODBUS, one byte, reflected
  function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/mrc_frame.sv =====
// Frame tracker: running CRC, byte captures and end-of-frame status.
`default_nettype none
module mrc_frame import mrc_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     take_en,
  input  wire in_req_t  req,
  input  wire cfg_t     cfg,
  output logic          res_load,
  output out_rsp_t      res
);

  localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_FRAME);

  logic [POS_W-1:0]  pos_r, pos_nxt, pos_upd;
  logic [WORD_W-1:0] crc_r, crc_nxt, crc_upd;
  logic [BYTE_W-1:0] addr_r, addr_nxt, addr_upd;
  logic [BYTE_W-1:0] func_r, func_nxt, func_upd;
  logic [BYTE_W-1:0] count_r, count_nxt, count_upd;
  logic [WORD_W-1:0] value_r, value_nxt, value_upd;
  logic              bit_r, bit_nxt, bit_upd;
  logic [WORD_W-1:0] fault_r, fault_nxt, fault_upd;
  logic              ovf_r, ovf_nxt, ovf_upd;

  logic [POS_W-1:0]  vpos, cpos, fpos;
  logic [BYTE_W-1:0] b;
  logic [2:0]        status;

  assign b = req.data_byte;
  assign vpos = POS_DATA + {1'b0, cfg.value_word_index, 1'b0};
  assign cpos = POS_DATA + {1'b0, cfg.coil_index[10:3]};
  assign fpos = POS_FUNC + {1'b0, count_r[7:1], 1'b0};

  always_comb begin
    pos_upd = pos_r;
    crc_upd = crc_r;
    addr_upd = addr_r;
    func_upd = func_r;
    count_upd = count_r;
    value_upd = value_r;
    bit_upd = bit_r;
    fault_upd = fault_r;
    ovf_upd = ovf_r;
    if (pos_r < MaxPos) begin
      if (pos_r == POS_ADDR) begin
        addr_upd = b;
      end
      if (pos_r == POS_FUNC) begin
        func_upd = b;
      end
      if (pos_r == POS_COUNT) begin
        count_upd = b;
        // byte count below two: fault word is function and count bytes
        if (b[7:1] == 7'd0) begin
          fault_upd = {func_r, b};
        end
      end
      if (pos_r >= POS_DATA) begin
        if (pos_r == vpos) begin
          value_upd[15:8] = b;
        end
        if (pos_r == vpos + 9'd1) begin
          value_upd[7:0] = b;
        end
        if (pos_r == cpos) begin
          bit_upd = b[cfg.coil_index[2:0]];
        end
        if (pos_r == fpos) begin
          fault_upd[15:8] = b;
        end
        if (pos_r == fpos + 9'd1) begin
          fault_upd[7:0] = b;
        end
      end
      crc_upd = crc16_byte(crc_r, b);
      pos_upd = pos_r + 9'd1;
    end else begin
      ovf_upd = 1'b1;
    end
  end

  always_comb begin
    if (pos_upd < MIN_FRAME || ovf_upd) begin
      status = ST_LENGTH;
    end else if (cfg.expected_address != 8'd0 && addr_upd != cfg.expected_address) begin
      status = ST_ADDRESS;
    end else if (func_upd != cfg.expected_function) begin
      status = ST_FUNCTION;
    end else if (cfg.expected_byte_count != 8'd0 && count_upd != cfg.expected_byte_count) begin
      status = ST_COUNT;
    end else if (crc_upd != 16'd0) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_load = take_en && req.last_byte;
    res.status = status;
    res.frame_length = pos_upd;
    res.value_word = (status == ST_OK) ? value_upd : 16'd0;
    res.value_bit = (status == ST_OK) ? bit_upd : 1'b0;
    res.fault_word = (status == ST_OK && pos_upd >= FAULT_MIN_LEN) ? fault_upd : 16'd0;
  end

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    addr_nxt = addr_r;
    func_nxt = func_r;
    count_nxt = count_r;
    value_nxt = value_r;
    bit_nxt = bit_r;
    fault_nxt = fault_r;
    ovf_nxt = ovf_r;
    if (take_en) begin
      if (req.last_byte) begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
        addr_nxt = '0;
        func_nxt = '0;
        count_nxt = '0;
        value_nxt = '0;
        bit_nxt = 1'b0;
        fault_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        pos_nxt = pos_upd;
        crc_nxt = crc_upd;
        addr_nxt = addr_upd;
        func_nxt = func_upd;
        count_nxt = count_upd;
        value_nxt = value_upd;
        bit_nxt = bit_upd;
        fault_nxt = fault_upd;
        ovf_nxt = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= CRC_INIT;
      addr_r <= '0;
      func_r <= '0;
      count_r <= '0;
      value_r <= '0;
      bit_r <= 1'b0;
      fault_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      addr_r <= addr_nxt;
      func_r <= func_nxt;
      count_r <= count_nxt;
      value_r <= value_nxt;
      bit_r <= bit_nxt;
      fault_r <= fault_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/mrc_result_reg.sv =====
// Result register: holds one finished request result until downstream takes it.
`default_nettype none
module mrc_result_reg import mrc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     res_load,
  input  wire out_rsp_t res,
  input  wire logic     out_stall,
  output logic          out_valid,
  output out_rsp_t      out_data,
  output logic          busy
);

  logic     valid_r, valid_nxt;
  out_rsp_t data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    data_nxt = data_r;
    if (res_load) begin
      valid_nxt = 1'b1;
      data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data = data_r;
  assign busy = valid_r && out_stall;

endmodule
`default_nettype wire

// ===== design/modbus_rtu_response_checker_core.sv =====
// Top level: Modbus RTU response checker with configuration registers.
`default_nettype none
// Takes one response byte per cycle and keeps a running CRC-16/MODBUS; on the
// byte marked last it registers one result (status, length, selected word,
// coil bit, fault word) that appears on out_ the cycle after. Throughput is
// one byte per clock, set by the byte-wide CRC update between the frame state
// registers and the result register. Only a last byte is held off, and only
// while the previous result is still stalled. Configuration writes are always
// ready; write them while no frame is in progress.
module modbus_rtu_response_checker_core import mrc_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_req_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_rsp_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     take_en;
  logic     res_load;
  logic     busy;
  out_rsp_t res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_EXP_ADDR:  cfg_nxt.expected_address = cfg_data[7:0];
        REG_EXP_FUNC:  cfg_nxt.expected_function = cfg_data[7:0];
        REG_EXP_COUNT: cfg_nxt.expected_byte_count = cfg_data[7:0];
        REG_WORD_IDX:  cfg_nxt.value_word_index = cfg_data[6:0];
        REG_COIL_IDX:  cfg_nxt.coil_index = cfg_data[10:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_address <= '0;
      cfg_r.expected_function <= FUNC_RESET;
      cfg_r.expected_byte_count <= '0;
      cfg_r.value_word_index <= '0;
      cfg_r.coil_index <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = busy && in_data.last_byte;
  assign take_en = in_valid && !in_stall;

  mrc_frame #(
    .MAX_FRAME(MAX_FRAME)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .take_en  (take_en),
    .req      (in_data),
    .cfg      (cfg_r),
    .res_load (res_load),
    .res      (res)
  );

  mrc_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .busy      (busy)
  );

endmodule
`default_nettype wire
